[rtl/core/acfb8_pkg.sv]
// Shared types, constants and round functions of the AES-128 CFB-8 stream cipher.
package acfb8_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_HIGH = 3'd0,
    CFG_KEY_LOW  = 3'd1,
    CFG_IV_HIGH  = 3'd2,
    CFG_IV_LOW   = 3'd3,
    CFG_DECRYPT  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_in;
    logic       restart;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic         start;
    logic [127:0] block;
    logic [127:0] key;
  } rnd_req_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Next round key of the AES-128 schedule from the current one.
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] t;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rcon, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // One cipher round; byte 0 of the state is the most significant byte.
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [7:0] all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[4*c+i] = SBOX[b[4*((c+i)%4)+i]];
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      for (int i = 0; i < 4; i++)
        o[4*c+i] = last ? t[4*c+i] :
                   t[4*c+i] ^ all ^ gf_dbl(t[4*c+i] ^ t[4*c+((i+1)%4)]);
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = o[i];
    return r;
  endfunction

endpackage

[rtl/core/aes128_cfb8_stream_cipher_core.sv]
// Top level of the AES-128 CFB-8 stream cipher core.
// Input transfers carry one data byte with restart and last marks; each yields
// exactly one output transfer with the processed byte and the copied last mark.
// Configuration is a plain write port: key halves, IV halves and the decrypt
// mode bit, to be written only while the core is idle; the core itself does not
// enforce this. The key takes effect from the next byte; the IV is loaded into
// the feedback register by a restart byte. Each byte is encrypted by one shared
// round unit that runs one AES round per cycle, and in_stall_o stays high from
// input transfer until the result enters the output register; no new byte is
// taken while a byte is in the round unit. The next byte is taken once the result
// sits in the output register; one more byte can start while it waits, and the
// core then holds until the receiver removes its stall.
// Reset clears the key, IV and feedback register to zero and empties the core.
module aes128_cfb8_stream_cipher_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  acfb8_pkg::in_item_t     in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output acfb8_pkg::out_item_t    out_data_o,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [63:0]             cfg_data_i
);
  import acfb8_pkg::*;

  logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic         dec_q;
  logic [127:0] fb_q, fb_d;
  logic         busy_q;
  in_item_t     item_q;
  logic         ovalid_q;
  out_item_t    odata_q;
  logic         in_acc, done, out_free, fin;
  logic [7:0]   ks, dout, fbb;
  rnd_req_t     req;

  assign out_free   = !ovalid_q || !out_stall_i;
  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;

  always_comb begin
    fb_d = in_data_i.restart ? {iv_hi_q, iv_lo_q} : fb_q;
  end

  assign req.start = in_acc;
  assign req.block = fb_d;
  assign req.key   = {key_hi_q, key_lo_q};

  acfb8_round_unit u_round (
    .clk_i,
    .rst_ni,
    .req_i        (req),
    .done_o       (done),
    .first_byte_o (ks)
  );

  // The round unit holds its final state until the output register is free.
  logic done_q;
  assign dout = item_q.data_in ^ ks;
  assign fbb  = dec_q ? item_q.data_in : dout;
  assign fin  = (done || done_q) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q  <= '0;
      iv_lo_q  <= '0;
      dec_q    <= 1'b0;
      fb_q     <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_KEY_HIGH: key_hi_q <= cfg_data_i;
          CFG_KEY_LOW:  key_lo_q <= cfg_data_i;
          CFG_IV_HIGH:  iv_hi_q  <= cfg_data_i;
          CFG_IV_LOW:   iv_lo_q  <= cfg_data_i;
          CFG_DECRYPT:  dec_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (fin) begin
        done_q   <= 1'b0;
        busy_q   <= 1'b0;
        ovalid_q <= 1'b1;
        fb_q     <= {fb_q[119:0], fbb};
      end else begin
        if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
        if (done) done_q <= 1'b1;
        if (in_acc) begin
          busy_q <= 1'b1;
          fb_q   <= fb_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_data_i;
    if (fin) begin
      odata_q.data_out <= dout;
      odata_q.last_out <= item_q.last_in;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
endmodule

[rtl/core/acfb8_round_unit.sv]
// Iterative AES-128 encryption unit: one round and one key step per cycle.
module acfb8_round_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  acfb8_pkg::rnd_req_t req_i,
  output logic                done_o,
  output logic [7:0]          first_byte_o
);
  import acfb8_pkg::*;

  logic [127:0] state_q, state_d;
  logic [127:0] rkey_q, rkey_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [3:0]   round_q, round_d;
  logic         busy_q, busy_d;
  logic [127:0] key_nx;

  assign key_nx = next_key(rkey_q, rcon_q);

  always_comb begin
    state_d = state_q;
    rkey_d  = rkey_q;
    rcon_d  = rcon_q;
    round_d = round_q;
    busy_d  = busy_q;
    if (req_i.start) begin
      state_d = req_i.block ^ req_i.key;
      rkey_d  = req_i.key;
      rcon_d  = 8'h01;
      round_d = 4'd1;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      state_d = enc_round(state_q, round_q == 4'd10) ^ key_nx;
      rkey_d  = key_nx;
      rcon_d  = gf_dbl(rcon_q);
      round_d = round_q + 4'd1;
      busy_d  = round_q != 4'd10;
    end else if (round_q == 4'd11) begin
      round_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      round_q <= '0;
    end else begin
      busy_q  <= busy_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    rkey_q  <= rkey_d;
    rcon_q  <= rcon_d;
  end

  assign done_o       = round_q == 4'd11;
  assign first_byte_o = state_q[127:120];
endmodule
